@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mbr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbr_pkg
// types and constants of the mirror-ball reflection vector pipeline
// ----------------------------------------------------------------------------
package mbr_pkg;

    localparam int FRAC_BITS = 30;
    localparam int MAX_SIZE  = 4096;

    localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);

    localparam int PIX_W  = 12;
    localparam int REFL_W = 32;
    localparam int TW_W   = 13;
    localparam int INV_W  = 31;

    typedef logic [1:0]        t_cfg_idx;
    typedef logic [INV_W-1:0]  t_cfg_data;
    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic signed [REFL_W-1:0] t_refl;

    localparam t_cfg_idx CFG_TEX_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_INV_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_INV_HEIGHT = 2'd2;

    localparam logic [TW_W-1:0]  TEX_WIDTH_RST = 13'd256;
    localparam logic [INV_W-1:0] INV_SPAN_RST  = 31'd4210752;

endpackage

@@ rtl/core/mbr_pix_if.sv @@
// ----------------------------------------------------------------------------
// mbr_pix_if
// pixel coordinate channel, valid/ready
// ----------------------------------------------------------------------------
interface mbr_pix_if;
    import mbr_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_x;
    t_pix pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ rtl/core/mbr_refl_if.sv @@
// ----------------------------------------------------------------------------
// mbr_refl_if
// reflection vector channel, valid/ready
// ----------------------------------------------------------------------------
interface mbr_refl_if;
    import mbr_pkg::*;

    logic  valid;
    logic  ready;
    t_refl refl_x;
    t_refl refl_y;
    t_refl refl_z;
    logic  inside_disc;

    modport source (output valid, output refl_x, output refl_y, output refl_z,
                    output inside_disc, input ready);
    modport sink   (input valid, input refl_x, input refl_y, input refl_z,
                    input inside_disc, output ready);
endinterface

@@ rtl/core/mbr_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// mbr_sqrt_pipe
// pipelined floor integer square root, a few root bits per stage
// ----------------------------------------------------------------------------
module mbr_sqrt_pipe #(
    parameter int IN_W   = 64,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [IN_W/2-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int RT_W = IN_W / 2;
    localparam int RW   = RT_W + 3;
    localparam int NSTG = RT_W / STEPS;

    logic              r_vld  [NSTG];
    logic [RW-1:0]     r_rem  [NSTG];
    logic [RT_W-1:0]   r_root [NSTG];
    logic [IN_W-1:0]   r_x    [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic              s_vld;
        logic [RW-1:0]     s_rem;
        logic [RT_W-1:0]   s_root;
        logic [IN_W-1:0]   s_x;
        logic [SIDE_W-1:0] s_side;
        logic [RW-1:0]     n_rem;
        logic [RT_W-1:0]   n_root;
        logic [IN_W-1:0]   n_x;
        logic [RW-1:0]     n_rs;
        logic [RW-1:0]     n_trial;

        if (g == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_x    = i_rad;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_root = r_root[g-1];
            assign s_x    = r_x[g-1];
            assign s_side = r_side[g-1];
        end

        // restoring square root, two radicand bits per step
        always_comb begin
            n_rem   = s_rem;
            n_root  = s_root;
            n_x     = s_x;
            n_rs    = '0;
            n_trial = '0;
            for (int k = 0; k < STEPS; k++) begin
                n_rs    = {n_rem[RW-3:0], n_x[IN_W-1 -: 2]};
                n_x     = {n_x[IN_W-3:0], 2'b00};
                n_trial = {1'b0, n_root, 2'b01};
                if (n_rs >= n_trial) begin
                    n_rem  = n_rs - n_trial;
                    n_root = {n_root[RT_W-2:0], 1'b1};
                end else begin
                    n_rem  = n_rs;
                    n_root = {n_root[RT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= s_vld;
            end
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_x[g]    <= n_x;
                r_side[g] <= s_side;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_root = r_root[NSTG-1];
    assign o_side = r_side[NSTG-1];
endmodule

@@ rtl/core/mbr_div_pipe.sv @@
// ----------------------------------------------------------------------------
// mbr_div_pipe
// pipelined restoring divider, a few quotient bits per stage
// the upper DEN_W bits of the dividend must be below the divisor
// ----------------------------------------------------------------------------
module mbr_div_pipe #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]       i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_vld,
    output logic [NUM_W-DEN_W-1:0] o_quot,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int LOW_W = NUM_W - DEN_W;
    localparam int NSTG  = LOW_W / STEPS;

    logic              r_vld  [NSTG];
    logic [DEN_W:0]    r_rem  [NSTG];
    logic [LOW_W-1:0]  r_x    [NSTG];
    logic [LOW_W-1:0]  r_quot [NSTG];
    logic [DEN_W-1:0]  r_den  [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic              s_vld;
        logic [DEN_W:0]    s_rem;
        logic [LOW_W-1:0]  s_x;
        logic [LOW_W-1:0]  s_quot;
        logic [DEN_W-1:0]  s_den;
        logic [SIDE_W-1:0] s_side;
        logic [DEN_W:0]    n_rem;
        logic [LOW_W-1:0]  n_x;
        logic [LOW_W-1:0]  n_quot;
        logic [DEN_W:0]    n_rs;

        if (g == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = {1'b0, i_num[NUM_W-1 -: DEN_W]};
            assign s_x    = i_num[LOW_W-1:0];
            assign s_quot = '0;
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_x    = r_x[g-1];
            assign s_quot = r_quot[g-1];
            assign s_den  = r_den[g-1];
            assign s_side = r_side[g-1];
        end

        always_comb begin
            n_rem  = s_rem;
            n_x    = s_x;
            n_quot = s_quot;
            n_rs   = '0;
            for (int k = 0; k < STEPS; k++) begin
                n_rs = {n_rem[DEN_W-1:0], n_x[LOW_W-1]};
                n_x  = {n_x[LOW_W-2:0], 1'b0};
                if (n_rs >= {1'b0, s_den}) begin
                    n_rem  = n_rs - {1'b0, s_den};
                    n_quot = {n_quot[LOW_W-2:0], 1'b1};
                end else begin
                    n_rem  = n_rs;
                    n_quot = {n_quot[LOW_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= s_vld;
            end
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_x[g]    <= n_x;
                r_quot[g] <= n_quot;
                r_den[g]  <= s_den;
                r_side[g] <= s_side;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_quot = r_quot[NSTG-1];
    assign o_side = r_side[NSTG-1];
endmodule

@@ rtl/core/mirror_ball_pixel_to_reflection.sv @@
// ----------------------------------------------------------------------------
// mirror_ball_pixel_to_reflection: pipelined path from transaction in to result
// throughput one pixel per cycle; the whole pipeline stalls while the output waits
// holds two 8-stage square roots and three parallel 8-stage dividers, 4 bits per stage
// synchronous active-low reset clears valid bits and restores config defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mirror_ball_pixel_to_reflection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  mbr_pkg::t_cfg_idx  i_cfg_idx,
    input  mbr_pkg::t_cfg_data i_cfg_data,
    mbr_pix_if.sink            i_pix,
    mbr_refl_if.source         o_refl
);
    import mbr_pkg::*;

    localparam logic signed [31:0] ONE_S = signed'(32'(ONE_Q));

    // configuration
    logic [TW_W-1:0]  r_tex_width;
    logic [INV_W-1:0] r_inv_w;
    logic [INV_W-1:0] r_inv_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width <= TEX_WIDTH_RST;
            r_inv_w     <= INV_SPAN_RST;
            r_inv_h     <= INV_SPAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEX_WIDTH:  r_tex_width <= i_cfg_data[TW_W-1:0];
                CFG_INV_WIDTH:  r_inv_w     <= i_cfg_data;
                CFG_INV_HEIGHT: r_inv_h     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en          = !o_refl.valid || o_refl.ready;
    assign i_pix.ready = en;

    function automatic logic signed [32:0] rnd_away(input logic signed [63:0] v,
                                                    input int sh);
        logic [63:0] mag;
        logic [63:0] rm;
        begin
            mag = v[63] ? 64'(-v) : 64'(v);
            rm  = (mag + (64'd1 << (sh - 1))) >> sh;
            rnd_away = v[63] ? -signed'(33'(rm)) : signed'(33'(rm));
        end
    endfunction

    // stage a: coordinate products and disc offsets
    logic              r_a_vld;
    logic [43:0]       r_a_tx, r_a_ty;
    logic signed [12:0] r_a_dx, r_a_dy;
    logic [11:0]       r_a_r;
    logic [TW_W-1:0]   n_w;
    logic [11:0]       n_r;

    assign n_w = (r_tex_width > TW_W'(MAX_SIZE)) ? TW_W'(MAX_SIZE) : r_tex_width;
    assign n_r = n_w[TW_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else if (en)  r_a_vld <= i_pix.valid;
        if (en) begin
            r_a_tx <= 44'({i_pix.pixel_x, 1'b0}) * 44'(r_inv_w);
            r_a_ty <= 44'({i_pix.pixel_y, 1'b0}) * 44'(r_inv_h);
            r_a_dx <= signed'({1'b0, i_pix.pixel_x}) - signed'({1'b0, n_r});
            r_a_dy <= signed'({1'b0, i_pix.pixel_y}) - signed'({1'b0, n_r});
            r_a_r  <= n_r;
        end
    end

    // stage b: u, v and squared disc distances
    logic               r_b_vld;
    logic signed [31:0] r_b_u, r_b_v;
    logic [25:0]        r_b_d2;
    logic [23:0]        r_b_r2;
    logic [31:0]        n_tsx, n_tsy;
    logic signed [25:0] n_dxx, n_dyy;

    // saturate at 2.0 in q.30
    assign n_tsx = (r_a_tx > 44'(33'd1 << 31)) ? 32'h8000_0000 : r_a_tx[31:0];
    assign n_tsy = (r_a_ty > 44'(33'd1 << 31)) ? 32'h8000_0000 : r_a_ty[31:0];
    assign n_dxx = r_a_dx * r_a_dx;
    assign n_dyy = r_a_dy * r_a_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else if (en)  r_b_vld <= r_a_vld;
        if (en) begin
            r_b_u  <= signed'(n_tsx - 32'(ONE_Q));
            r_b_v  <= signed'(n_tsy - 32'(ONE_Q));
            r_b_d2 <= 26'(n_dxx) + 26'(n_dyy);
            r_b_r2 <= r_a_r * r_a_r;
        end
    end

    // stage c: squares of u and v, disc decision
    logic               r_c_vld;
    logic signed [31:0] r_c_u, r_c_v;
    logic [60:0]        r_c_usq, r_c_vsq;
    logic               r_c_in;
    logic signed [63:0] n_uu, n_vv;

    assign n_uu = r_b_u * r_b_u;
    assign n_vv = r_b_v * r_b_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else if (en)  r_c_vld <= r_b_vld;
        if (en) begin
            r_c_u   <= r_b_u;
            r_c_v   <= r_b_v;
            r_c_usq <= n_uu[60:0];
            r_c_vsq <= n_vv[60:0];
            r_c_in  <= (r_b_d2 <= 26'(r_b_r2));
        end
    end

    // stage d: radicand clamped at zero
    logic               r_d_vld;
    logic signed [31:0] r_d_u, r_d_v;
    logic [60:0]        r_d_rad;
    logic               r_d_in;
    logic signed [62:0] n_radw;

    assign n_radw = signed'(63'(ONE_SQ)) - signed'(63'(r_c_usq)) - signed'(63'(r_c_vsq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else if (en)  r_d_vld <= r_c_vld;
        if (en) begin
            r_d_u   <= r_c_u;
            r_d_v   <= r_c_v;
            r_d_rad <= n_radw[62] ? '0 : n_radw[60:0];
            r_d_in  <= r_c_in;
        end
    end

    // normal z
    logic        s1_vld;
    logic [31:0] s1_root;
    logic [64:0] s1_side;

    mbr_sqrt_pipe #(.IN_W(64), .STEPS(4), .SIDE_W(65)) u_sqrt_nz (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_d_vld),
        .i_rad  ({3'b000, r_d_rad}),
        .i_side ({r_d_u, r_d_v, r_d_in}),
        .o_vld  (s1_vld),
        .o_root (s1_root),
        .o_side (s1_side)
    );

    // stage e: nz products
    logic               r_e_vld;
    logic signed [63:0] r_e_px, r_e_py;
    logic [60:0]        r_e_pz;
    logic               r_e_in;
    logic signed [31:0] n_nz;
    logic [61:0]        n_pz;

    assign n_nz = signed'({1'b0, s1_root[30:0]});
    assign n_pz = s1_root[30:0] * s1_root[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else if (en)  r_e_vld <= s1_vld;
        if (en) begin
            r_e_px <= n_nz * signed'(s1_side[64:33]);
            r_e_py <= n_nz * signed'(s1_side[32:1]);
            r_e_pz <= n_pz[60:0];
            r_e_in <= s1_side[0];
        end
    end

    // stage f: reflection components rounded to qF
    logic               r_f_vld;
    logic signed [32:0] r_f_rx, r_f_ry, r_f_rz;
    logic               r_f_in;
    logic signed [63:0] n_zv;

    assign n_zv = signed'({2'b00, r_e_pz, 1'b0}) - signed'(ONE_SQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_vld <= 1'b0;
        else if (en)  r_f_vld <= r_e_vld;
        if (en) begin
            // 2*p rounded by 30 bits is p rounded by 29 bits
            r_f_rx <= rnd_away(r_e_px, FRAC_BITS - 1);
            r_f_ry <= rnd_away(r_e_py, FRAC_BITS - 1);
            r_f_rz <= rnd_away(n_zv, FRAC_BITS);
            r_f_in <= r_e_in;
        end
    end

    // stage g: squares of the components
    logic               r_g_vld;
    logic signed [32:0] r_g_rx, r_g_ry, r_g_rz;
    logic [63:0]        r_g_sx, r_g_sy, r_g_sz;
    logic               r_g_in;
    logic signed [65:0] n_sx, n_sy, n_sz;

    assign n_sx = r_f_rx * r_f_rx;
    assign n_sy = r_f_ry * r_f_ry;
    assign n_sz = r_f_rz * r_f_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_vld <= 1'b0;
        else if (en)  r_g_vld <= r_f_vld;
        if (en) begin
            r_g_rx <= r_f_rx;
            r_g_ry <= r_f_ry;
            r_g_rz <= r_f_rz;
            r_g_sx <= n_sx[63:0];
            r_g_sy <= n_sy[63:0];
            r_g_sz <= n_sz[63:0];
            r_g_in <= r_f_in;
        end
    end

    // stage h: squared length
    logic               r_h_vld;
    logic signed [32:0] r_h_rx, r_h_ry, r_h_rz;
    logic [63:0]        r_h_len2;
    logic               r_h_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_vld <= 1'b0;
        else if (en)  r_h_vld <= r_g_vld;
        if (en) begin
            r_h_rx   <= r_g_rx;
            r_h_ry   <= r_g_ry;
            r_h_rz   <= r_g_rz;
            r_h_len2 <= r_g_sx + r_g_sy + r_g_sz;
            r_h_in   <= r_g_in;
        end
    end

    // length
    logic        s2_vld;
    logic [31:0] s2_len;
    logic [99:0] s2_side;

    mbr_sqrt_pipe #(.IN_W(64), .STEPS(4), .SIDE_W(100)) u_sqrt_len (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_h_vld),
        .i_rad  (r_h_len2),
        .i_side ({r_h_rx, r_h_ry, r_h_rz, r_h_in}),
        .o_vld  (s2_vld),
        .o_root (s2_len),
        .o_side (s2_side)
    );

    // stage i: dividends for normalization
    logic        r_i_vld;
    logic [63:0] r_i_nx, r_i_ny, r_i_nz;
    logic [31:0] r_i_len;
    logic        r_i_sx, r_i_sy, r_i_sz, r_i_lz, r_i_in;
    logic signed [32:0] n_cx, n_cy, n_cz;
    logic [32:0] n_mx, n_my, n_mz;

    assign n_cx = signed'(s2_side[99:67]);
    assign n_cy = signed'(s2_side[66:34]);
    assign n_cz = signed'(s2_side[33:1]);
    assign n_mx = n_cx[32] ? 33'(-n_cx) : 33'(n_cx);
    assign n_my = n_cy[32] ? 33'(-n_cy) : 33'(n_cy);
    assign n_mz = n_cz[32] ? 33'(-n_cz) : 33'(n_cz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_i_vld <= 1'b0;
        else if (en)  r_i_vld <= s2_vld;
        if (en) begin
            r_i_nx  <= (64'(n_mx) << FRAC_BITS) + 64'(s2_len[31:1]);
            r_i_ny  <= (64'(n_my) << FRAC_BITS) + 64'(s2_len[31:1]);
            r_i_nz  <= (64'(n_mz) << FRAC_BITS) + 64'(s2_len[31:1]);
            r_i_len <= s2_len;
            r_i_sx  <= n_cx[32];
            r_i_sy  <= n_cy[32];
            r_i_sz  <= n_cz[32];
            r_i_lz  <= (s2_len == '0);
            r_i_in  <= s2_side[0];
        end
    end

    // normalization dividers
    logic        dx_vld, dy_vld, dz_vld;
    logic [31:0] dx_q, dy_q, dz_q;
    logic [2:0]  dx_side;
    logic        dy_side, dz_side;

    mbr_div_pipe #(.NUM_W(64), .DEN_W(32), .STEPS(4), .SIDE_W(3)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_i_vld),
        .i_num(r_i_nx), .i_den(r_i_len), .i_side({r_i_lz, r_i_in, r_i_sx}),
        .o_vld(dx_vld), .o_quot(dx_q), .o_side(dx_side)
    );

    mbr_div_pipe #(.NUM_W(64), .DEN_W(32), .STEPS(4), .SIDE_W(1)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_i_vld),
        .i_num(r_i_ny), .i_den(r_i_len), .i_side(r_i_sy),
        .o_vld(dy_vld), .o_quot(dy_q), .o_side(dy_side)
    );

    mbr_div_pipe #(.NUM_W(64), .DEN_W(32), .STEPS(4), .SIDE_W(1)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_i_vld),
        .i_num(r_i_nz), .i_den(r_i_len), .i_side(r_i_sz),
        .o_vld(dz_vld), .o_quot(dz_q), .o_side(dz_side)
    );

    // output register: saturate to one, restore sign, zero-length fallback
    logic        r_o_vld;
    t_refl       r_o_x, r_o_y, r_o_z;
    logic        r_o_in;
    logic [31:0] n_qx, n_qy, n_qz;

    assign n_qx = (dx_q > 32'(ONE_Q)) ? 32'(ONE_Q) : dx_q;
    assign n_qy = (dy_q > 32'(ONE_Q)) ? 32'(ONE_Q) : dy_q;
    assign n_qz = (dz_q > 32'(ONE_Q)) ? 32'(ONE_Q) : dz_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else if (en)  r_o_vld <= dx_vld && dy_vld && dz_vld;
        if (en) begin
            if (dx_side[2]) begin
                r_o_x <= '0;
                r_o_y <= '0;
                r_o_z <= -ONE_S;
            end else begin
                r_o_x <= dx_side[0] ? -signed'(n_qx) : signed'(n_qx);
                r_o_y <= dy_side    ? -signed'(n_qy) : signed'(n_qy);
                r_o_z <= dz_side    ? -signed'(n_qz) : signed'(n_qz);
            end
            r_o_in <= dx_side[1];
        end
    end

    assign o_refl.valid       = r_o_vld;
    assign o_refl.refl_x      = r_o_x;
    assign o_refl.refl_y      = r_o_y;
    assign o_refl.refl_z      = r_o_z;
    assign o_refl.inside_disc = r_o_in;

    `MBR_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        o_refl.valid && !o_refl.ready, !i_pix.ready, "input taken while output stalled")
    `MBR_ASSERT_NOW(a_z_in_range, i_clk, i_rst_n, o_refl.valid,
        (o_refl.refl_z <= ONE_S) && (o_refl.refl_z >= -ONE_S), "refl_z beyond unit range")
    `MBR_ASSERT_NOW(a_x_in_range, i_clk, i_rst_n, o_refl.valid,
        (o_refl.refl_x <= ONE_S) && (o_refl.refl_x >= -ONE_S), "refl_x beyond unit range")
    `MBR_ASSERT_NEXT(a_stall_holds_stage, i_clk, i_rst_n, !i_pix.ready,
        $stable(r_a_tx) && $stable(r_a_vld), "first stage moved during stall")
endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// mirror-ball pixel to reflection vector testbench
// streams pixel coordinates over several map settings, including the extremes,
// predicts each reflection vector and disc flag in fixed point, and compares
// every result field by field, with both sides stalling at random in most phases
// ----------------------------------------------------------------------------
module testbench;
    import mbr_pkg::*;

    localparam longint ONE      = 64'sd1 << 30;
    localparam int     DRAIN    = 40;
    localparam int     LIMIT    = 400000;

    typedef struct packed {
        t_pix px;
        t_pix py;
    } t_coord;

    typedef struct packed {
        t_refl x;
        t_refl y;
        t_refl z;
        logic  disc;
    } t_vec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_idx = CFG_TEX_WIDTH;
    t_cfg_data i_cfg_data = '0;

    mbr_pix_if  pix ();
    mbr_refl_if refl ();

    mirror_ball_pixel_to_reflection DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_refl     (refl)
    );

    always #2 i_clk = ~i_clk;

    // map settings mirrored by the predictor
    logic [12:0] map_width = TEX_WIDTH_RST;
    logic [30:0] inv_w_span = INV_SPAN_RST;
    logic [30:0] inv_h_span = INV_SPAN_RST;

    t_coord pixel_queue[$];
    t_vec   vector_queue[$];
    int     idle_pct = 27;
    int     fail_count = 0;
    int     cycle_count = 0;
    bit     took = 1'b0;

    function automatic longint unsigned sqrt_floor(longint unsigned val);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > val) b = b >> 2;
        while (b != 0) begin
            if (val >= res + b) begin
                val = val - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_coord(t_pix p, logic [30:0] inv);
        longint unsigned t;
        t = 64'(p) * 64'(inv) * 2;
        if (t > (64'd1 << 31)) t = 64'd1 << 31;
        return longint'(t) - ONE;
    endfunction

    // Q60 to Q30, half away from zero
    function automatic longint round_q30(longint val);
        longint unsigned mag;
        mag = (val < 0) ? longint'(-val) : val;
        mag = (mag + (64'd1 << 29)) >> 30;
        return (val < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic t_refl unit_scale(longint c, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? longint'(-c) : c;
        q = (mag * longint'(ONE) + (len >> 1)) / len;
        if (q > ONE) q = ONE;
        return (c < 0) ? t_refl'(-longint'(q)) : t_refl'(q);
    endfunction

    function automatic t_vec reflect_pixel(t_coord c);
        t_vec o;
        longint u, v, rad, nz, rx, ry, rz, r, dx, dy, w;
        longint unsigned len;
        u = unit_coord(c.px, inv_w_span);
        v = unit_coord(c.py, inv_h_span);
        rad = ONE * ONE - u * u - v * v;
        if (rad < 0) rad = 0;
        nz = sqrt_floor(rad);
        rx = round_q30(2 * nz * u);
        ry = round_q30(2 * nz * v);
        rz = round_q30(2 * nz * nz - ONE * ONE);
        len = sqrt_floor(rx * rx + ry * ry + rz * rz);
        if (len == 0) begin
            o.x = '0;
            o.y = '0;
            o.z = t_refl'(-ONE);
        end else begin
            o.x = unit_scale(rx, len);
            o.y = unit_scale(ry, len);
            o.z = unit_scale(rz, len);
        end
        w = (map_width > MAX_SIZE) ? MAX_SIZE : map_width;
        r = w >> 1;
        dx = longint'(c.px) - r;
        dy = longint'(c.py) - r;
        o.disc = (dx * dx + dy * dy <= r * r);
        return o;
    endfunction

    // input side: accept at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && pix.valid && pix.ready) begin
            vector_queue.push_back(reflect_pixel({pix.pixel_x, pix.pixel_y}));
            took = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_coord c;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            pix.pixel_x <= '0;
            pix.pixel_y <= '0;
        end else if (pix.valid && !took) begin
            pix.valid <= 1'b1;
        end else if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
            c = pixel_queue.pop_front();
            pix.valid <= 1'b1;
            pix.pixel_x <= c.px;
            pix.pixel_y <= c.py;
        end else begin
            pix.valid <= 1'b0;
        end
        took = 1'b0;
        refl.ready <= i_rst_n && ($urandom_range(99) >= idle_pct);
    end

    // result side
    always @(posedge i_clk) begin
        t_vec e;
        if (i_rst_n && refl.valid && refl.ready) begin
            if (vector_queue.size() == 0) begin
                $error("unexpected result transaction");
                fail_count = fail_count + 1;
            end else begin
                e = vector_queue.pop_front();
                if (refl.refl_x !== e.x) begin
                    $error("refl_x expected %0d actual %0d", e.x, refl.refl_x);
                    fail_count = fail_count + 1;
                end
                if (refl.refl_y !== e.y) begin
                    $error("refl_y expected %0d actual %0d", e.y, refl.refl_y);
                    fail_count = fail_count + 1;
                end
                if (refl.refl_z !== e.z) begin
                    $error("refl_z expected %0d actual %0d", e.z, refl.refl_z);
                    fail_count = fail_count + 1;
                end
                if (refl.inside_disc !== e.disc) begin
                    $error("inside_disc expected %0b actual %0b", e.disc,
                           refl.inside_disc);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TEX_WIDTH:  map_width = val[12:0];
            CFG_INV_WIDTH:  inv_w_span = val;
            CFG_INV_HEIGHT: inv_h_span = val;
            default: ;
        endcase
    endtask

    task automatic set_map(int w, int iw, int ih);
        write_reg(CFG_TEX_WIDTH, t_cfg_data'(w));
        write_reg(CFG_INV_WIDTH, t_cfg_data'(iw));
        write_reg(CFG_INV_HEIGHT, t_cfg_data'(ih));
    endtask

    task automatic drain();
        wait (pixel_queue.size() == 0 && vector_queue.size() == 0 && !pix.valid);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // mostly coordinates within the map, the rest anywhere in the field
    task automatic push_random(int n, int span);
        t_coord c;
        repeat (n) begin
            if ($urandom_range(99) < 80) begin
                c.px = t_pix'($urandom_range(span - 1));
                c.py = t_pix'($urandom_range(span - 1));
            end else begin
                c.px = t_pix'($urandom);
                c.py = t_pix'($urandom);
            end
            pixel_queue.push_back(c);
        end
    endtask

    initial begin
        int w, h, span;
        pix.valid = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        refl.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset map: corners, center, disc rim, beyond the map
        pixel_queue.push_back('{12'd0, 12'd0});
        pixel_queue.push_back('{12'd255, 12'd255});
        pixel_queue.push_back('{12'd0, 12'd255});
        pixel_queue.push_back('{12'd255, 12'd0});
        pixel_queue.push_back('{12'd128, 12'd128});
        pixel_queue.push_back('{12'd127, 12'd128});
        pixel_queue.push_back('{12'd128, 12'd0});
        pixel_queue.push_back('{12'd0, 12'd128});
        pixel_queue.push_back('{12'd256, 12'd128});
        pixel_queue.push_back('{12'd4095, 12'd4095});
        pixel_queue.push_back('{12'd4095, 12'd0});
        pixel_queue.push_back('{12'd37, 12'd40});
        pixel_queue.push_back('{12'd220, 12'd215});
        pixel_queue.push_back('{12'd128, 12'd255});
        drain();

        // zero width: only the origin lies in the disc
        set_map(0, 0, 0);
        pixel_queue.push_back('{12'd0, 12'd0});
        pixel_queue.push_back('{12'd1, 12'd0});
        pixel_queue.push_back('{12'd0, 12'd1});
        drain();
        set_map(1, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        pixel_queue.push_back('{12'd0, 12'd0});
        pixel_queue.push_back('{12'd1, 12'd1});
        push_random(20, 4096);
        drain();

        // largest map, long stretch without any idling
        idle_pct = 0;
        set_map(4096, 262208, 262208);
        pixel_queue.push_back('{12'd2048, 12'd2048});
        pixel_queue.push_back('{12'd4095, 12'd2048});
        push_random(150, 4096);
        drain();
        idle_pct = 27;

        // width above the largest size clamps the disc radius
        set_map(8191, 262208, 131104);
        push_random(60, 4096);
        drain();
        set_map(2, 1 << 30, 1 << 30);
        pixel_queue.push_back('{12'd0, 12'd0});
        pixel_queue.push_back('{12'd1, 12'd1});
        pixel_queue.push_back('{12'd2, 12'd1});
        push_random(40, 2);
        drain();

        repeat (10) begin
            w = $urandom_range(4096, 2);
            h = $urandom_range(4096, 2);
            span = (w > 4095) ? 4096 : w;
            if ($urandom_range(9) == 0)
                set_map($urandom_range(8191), $urandom, $urandom);
            else
                set_map(w, (1 << 30) / (w - 1), (1 << 30) / (h - 1));
            push_random(80, span);
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mbr_pkg.sv
rtl/core/mbr_pix_if.sv
rtl/core/mbr_refl_if.sv
rtl/core/mbr_sqrt_pipe.sv
rtl/core/mbr_div_pipe.sv
rtl/core/mirror_ball_pixel_to_reflection.sv
sim/testbench.sv
